// File: rtl/xbm_pkg.sv
// Package for the XBM bitmap body decoder: payload, command and configuration
// types, character codes and register indexes. No dependencies.
package xbm_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int TOKEN_W     = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WORD_FORMAT  = 2'd2,
        CFG_CONVERT      = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       error_flag;
        logic       end_of_group;
    } t_out_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] image_width;
        logic [CFG_DATA_W-1:0] image_height;
        logic                  word_format;
        logic                  convert_for_load;
    } t_cfg;

    // Work handed from the front to the back: a closed token or end of input.
    typedef struct packed {
        logic               eoi;
        logic [TOKEN_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: rtl/xbm_front.sv
// Front of the XBM decoder: classifies characters and gathers hex tokens.
// Depends on xbm_pkg; pushes closed tokens and end of input into the queue.
module xbm_front import xbm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [TOKEN_W-1:0] r_token;
    logic [TOKEN_W-1:0] n_token;
    logic               r_open;
    logic               n_open;
    logic               is_digit;
    logic               is_delim;
    logic [3:0]         digit;
    logic [7:0]         c;

    assign c = i_item.char_code;

    always_comb begin
        is_digit = 1'b1;
        digit    = c[3:0];
        if (c inside {[CH_0:CH_9]}) begin
            digit = c[3:0];
        end else if (c inside {[CH_UA:CH_UF], [CH_LA:CH_LF]}) begin
            digit = c[3:0] + 4'd9;
        end else begin
            is_digit = 1'b0;
        end
        is_delim = c inside {CH_SPACE, CH_COMMA, CH_RBRACE, CH_NL, CH_TAB};
    end

    always_comb begin
        n_token     = r_token;
        n_open      = r_open;
        o_push      = 1'b0;
        o_cmd.eoi   = i_item.end_of_input;
        o_cmd.value = r_token;
        if (i_accept) begin
            if (i_item.end_of_input) begin
                o_push  = 1'b1;
                n_token = '0;
                n_open  = 1'b0;
            end else if (is_digit) begin
                n_token = {r_token[TOKEN_W-5:0], digit};
                n_open  = 1'b1;
            end else if (is_delim && r_open) begin
                o_push  = 1'b1;
                n_token = '0;
                n_open  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= '0;
            r_open  <= 1'b0;
        end else begin
            r_token <= n_token;
            r_open  <= n_open;
        end
    end

endmodule

// File: rtl/xbm_queue.sv
// Short command queue between the front and the back of the XBM decoder.
// Depends on xbm_pkg for the command type and the depth constants.
module xbm_queue import xbm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output t_queue_status o_status
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/xbm_back.sv
// Back of the XBM decoder: turns queued commands into bytes, keeps the row
// and image counters and drives the output register. Depends on xbm_pkg.
module xbm_back import xbm_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_cmd          i_cmd,
    input  t_queue_status i_status,
    output logic          o_pop,
    output logic          o_valid,
    output t_out_item     o_item,
    input  logic          i_stall
);

    // The register fields hold at most 8191, so that bounds the clamp too.
    localparam int DIM_MAX = (MAX_DIMENSION < 8191) ? MAX_DIMENSION : 8191;
    localparam int DW      = $clog2(DIM_MAX + 1) + 1;
    localparam int ROW_MAX = (DIM_MAX + 7) / 8;
    localparam int PW      = $clog2(ROW_MAX);
    localparam int RW      = $clog2(DIM_MAX);

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic          r_done;
    logic          n_done;
    logic          r_hi_pend;
    logic          n_hi_pend;
    logic [7:0]    r_hi;
    logic [7:0]    n_hi;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;

    logic [DW-1:0] width_c;
    logic [DW-1:0] height_c;
    logic [DW-1:0] row_len;
    logic          row_end;
    logic          last;
    logic          out_free;
    logic          emit;
    logic [7:0]    emit_byte;
    logic [7:0]    inv;
    logic [7:0]    conv;

    // The compare runs at the full register width so no high bits are lost.
    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (v > CFG_DATA_W'(DIM_MAX)) begin
            return DW'(DIM_MAX);
        end
        return DW'(v);
    endfunction

    assign width_c  = clamp_dim(i_cfg.image_width);
    assign height_c = clamp_dim(i_cfg.image_height);
    assign row_len  = (width_c + DW'(7)) >> 3;
    assign row_end  = (DW'(r_pos) + DW'(1)) >= row_len;
    assign last     = row_end && ((DW'(r_row) + DW'(1)) >= height_c);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        inv = ~emit_byte;
        for (int k = 0; k < 8; k++) begin
            conv[k] = inv[7-k];
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_row       = r_row;
        n_done      = r_done;
        n_hi_pend   = r_hi_pend;
        n_hi        = r_hi;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        emit        = 1'b0;
        emit_byte   = i_cmd.value[7:0];

        if (out_free) begin
            n_out_valid = 1'b0;
            if (r_hi_pend) begin
                // High byte of a word token; the low byte did not end the row.
                emit               = 1'b1;
                emit_byte          = r_hi;
                n_hi_pend          = 1'b0;
                n_out.end_of_group = 1'b1;
            end else if (!i_status.empty) begin
                o_pop = 1'b1;
                if (!r_done) begin
                    if (i_cmd.eoi) begin
                        n_done      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out       = '{data_byte: 8'h00, last_byte: 1'b0,
                                        error_flag: 1'b1, end_of_group: 1'b1};
                    end else begin
                        emit               = 1'b1;
                        n_hi               = i_cmd.value[15:8];
                        n_hi_pend          = i_cfg.word_format && !row_end;
                        n_out.end_of_group = !(i_cfg.word_format && !row_end);
                    end
                end
            end
        end

        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.data_byte  = i_cfg.convert_for_load ? conv : emit_byte;
            n_out.last_byte  = last;
            n_out.error_flag = 1'b0;
            if (row_end) begin
                n_pos = '0;
                if (last) begin
                    n_done = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_row       <= '0;
            r_done      <= 1'b0;
            r_hi_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_row       <= n_row;
            r_done      <= n_done;
            r_hi_pend   <= n_hi_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// File: rtl/xbm_hex_data_decoder_top.sv
// Top level of the XBM bitmap body decoder: configuration registers, front,
// command queue and back. Depends on xbm_pkg, xbm_front, xbm_queue, xbm_back.
//
// Usage: body characters, starting just after the opening brace, enter on the
// input channel (i_valid, i_in, o_stall); an item is taken at a clock edge with
// i_valid high and o_stall low. Decoded bytes leave on the output channel
// (o_valid, o_out, i_stall). Hex digits build a token; a space, comma, close
// brace, newline or tab ends an open token, which yields one byte, or two in
// the old 16-bit word format (the high byte is dropped when the low byte ends
// a row). End of input before the last byte yields one error item. After the
// image is done every input is taken and ignored until reset.
// Throughput: one character per cycle unless the queue is full; each byte goes
// through the output register; the four-entry command queue absorbs two-byte
// word tokens. A taken closing delimiter enters the queue, and its first byte
// then the output register, when nothing waits ahead. When the receiver stalls,
// the output item holds, the queue fills, and o_stall rises once it is full.
// Reset (i_rst_n low at a clock edge) clears token, counters, queue and output
// valid, and loads width 8, height 8, byte format and no conversion.
// Configuration writes are taken at any edge and belong to idle periods.
module xbm_hex_data_decoder_top import xbm_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_in_item              i_in,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out_item             o_out,
    input  logic                  i_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg          r_cfg;
    t_cfg          n_cfg;
    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_queue_status q_status;
    logic          push;
    logic          pop;
    logic          in_accept;

    // The front pushes at most one command per item, so a full queue is the
    // only reason to hold off the sender.
    assign o_stall   = q_status.full;
    assign in_accept = i_valid && !q_status.full;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  n_cfg.image_width      = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_cfg.image_height     = i_cfg_data;
                CFG_WORD_FORMAT:  n_cfg.word_format      = i_cfg_data[0];
                CFG_CONVERT:      n_cfg.convert_for_load = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{image_width: CFG_DATA_W'(8), image_height: CFG_DATA_W'(8),
                       word_format: 1'b0, convert_for_load: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    xbm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    xbm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    xbm_back #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (head_cmd),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_item   (o_out),
        .i_stall  (i_stall)
    );

endmodule

// File: tb/tb_xbm_hex_data_decoder_top.sv
// Self-checking testbench for xbm_hex_data_decoder_top: feeds bitmap body text and
// compares every decoded byte with a behavioral decoder kept inside this file.
// Depends on xbm_pkg and the decoder RTL.
module tb_xbm_hex_data_decoder_top import xbm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM       = 4096;
    // Bytes pass the queue and the output register; this covers that with margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_PHASES    = 8;

    // Behavioral decoder: tracks the token, the row position and the row count
    // exactly as the block should, and holds the bytes still owed by the block.
    class body_decoder_model;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        logic                  word_fmt;
        logic                  convert_en;
        logic [TOKEN_W-1:0]    token;
        bit                    token_open;
        int unsigned           pos_in_line;
        int unsigned           rows_done;
        bit                    done;
        t_out_item             pending_bytes[$];
        int                    mismatch_count;

        function new();
            width_reg      = 13'd8;
            height_reg     = 13'd8;
            word_fmt       = 1'b0;
            convert_en     = 1'b0;
            token          = '0;
            token_open     = 1'b0;
            pos_in_line    = 0;
            rows_done      = 0;
            done           = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = data;
                CFG_IMAGE_HEIGHT: height_reg = data;
                CFG_WORD_FORMAT:  word_fmt   = data[0];
                CFG_CONVERT:      convert_en = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        // Loader form: inverted, then bit order reversed.
        function logic [7:0] load_form(logic [7:0] b);
            logic [7:0] inv;
            logic [7:0] r;
            inv = ~b;
            if (!convert_en) return b;
            for (int k = 0; k < 8; k++) r[k] = inv[7-k];
            return r;
        endfunction

        // Queues one byte and advances the counters; returns 1 when the row ended.
        function bit push_byte(logic [7:0] b);
            int unsigned row_len;
            int unsigned rows_total;
            bit          row_end;
            t_out_item   res;
            row_len    = (clamp_dim(width_reg) + 7) >> 3;
            rows_total = clamp_dim(height_reg);
            row_end    = (pos_in_line + 1 >= row_len);
            res.data_byte    = load_form(b);
            res.last_byte    = 1'b0;
            res.error_flag   = 1'b0;
            res.end_of_group = 1'b0;
            if (row_end) begin
                pos_in_line = 0;
                if (rows_done + 1 >= rows_total) begin
                    res.last_byte = 1'b1;
                    done          = 1'b1;
                end else begin
                    rows_done++;
                end
            end else begin
                pos_in_line++;
            end
            pending_bytes.push_back(res);
            return row_end;
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9) return c - CH_0;
            if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
            if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
            return -1;
        endfunction

        function bit is_delim(logic [7:0] c);
            return c == CH_SPACE || c == CH_COMMA || c == CH_RBRACE || c == CH_NL
                || c == CH_TAB;
        endfunction

        function void take_char(t_in_item it);
            int                 digit;
            logic [TOKEN_W-1:0] v;
            bit                 row_end;
            t_out_item          res;
            if (done) return;
            if (it.end_of_input) begin
                token_open       = 1'b0;
                token            = '0;
                done             = 1'b1;
                res.data_byte    = 8'h00;
                res.last_byte    = 1'b0;
                res.error_flag   = 1'b1;
                res.end_of_group = 1'b1;
                pending_bytes.push_back(res);
                return;
            end
            digit = hex_value(it.char_code);
            if (digit >= 0) begin
                token      = {token[TOKEN_W-5:0], digit[3:0]};
                token_open = 1'b1;
                return;
            end
            if (!is_delim(it.char_code) || !token_open) return;
            v          = token;
            token      = '0;
            token_open = 1'b0;
            row_end = push_byte(v[7:0]);
            if (word_fmt && !row_end) void'(push_byte(v[15:8]));
            res = pending_bytes.pop_back();
            res.end_of_group = 1'b1;
            pending_bytes.push_back(res);
        endfunction

        function void match_output(t_out_item got);
            t_out_item want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: data_byte %02h last %b error %b group %b",
                       got.data_byte, got.last_byte, got.error_flag, got.end_of_group);
                mismatch_count++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
                mismatch_count++;
            end
            if (got.last_byte !== want.last_byte) begin
                $error("last_byte: expected %b, got %b", want.last_byte, got.last_byte);
                mismatch_count++;
            end
            if (got.error_flag !== want.error_flag) begin
                $error("error_flag: expected %b, got %b", want.error_flag, got.error_flag);
                mismatch_count++;
            end
            if (got.end_of_group !== want.end_of_group) begin
                $error("end_of_group: expected %b, got %b",
                       want.end_of_group, got.end_of_group);
                mismatch_count++;
            end
        endfunction
    endclass

    // Every block input starts at a known value; reset is held low from time zero.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    t_in_item              i_in       = '0;
    logic                  i_stall    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_out;

    body_decoder_model decoder;

    // Idling controls. A quiet side never idles, which gives back-to-back stretches.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold = 0;
    int results_taken = 0;
    int results_seen = 0;
    int items_sent = 0;

    xbm_hex_data_decoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in       (i_in),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side: a result item is taken at a rising edge with o_valid high and
    // i_stall low, and checked against the oldest byte the decoder still owes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            decoder.match_output(o_out);
            results_taken++;
        end
    end

    // After each taken result the receiver draws how many cycles it stalls next.
    // Stall is driven on the falling edge so the block sees a settled value.
    always @(negedge i_clk) begin
        if (results_seen != results_taken) begin
            results_seen = results_taken;
            rx_hold = rx_quiet ? 0 : $urandom_range(0, 8);
        end
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Offers one item after a random gap and returns at the falling edge after it
    // was taken. Valid stays high when the next item follows with no gap, so it is
    // never lowered and raised in the same step; any waiting caller lowers it first.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_stall);
        decoder.take_char(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] c);
        t_in_item it;
        it.char_code    = c;
        it.end_of_input = 1'b0;
        send_item(it);
    endtask

    // End of file; the character code rides along with random content.
    task automatic send_eoi();
        t_in_item it;
        it.char_code    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char(int nib, bit upper);
        if (nib < 10) return CH_0 + 8'(nib);
        return (upper ? CH_UA : CH_LA) + 8'(nib - 10);
    endfunction

    function automatic logic [7:0] pick_delim(int k);
        case (k)
            0:       return CH_SPACE;
            1:       return CH_COMMA;
            2:       return CH_RBRACE;
            3:       return CH_NL;
            default: return CH_TAB;
        endcase
    endfunction

    // One well-formed token with random content: optional 0x prefix, one to four
    // digits (now and then five or six, which overflow the 16-bit token), one
    // delimiter, sometimes a stray second delimiter, sometimes a noise byte first.
    task automatic send_token();
        int n_digits;
        if ($urandom_range(0, 7) == 0) send_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) send_text("0x");
        n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        repeat (n_digits) send_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
        send_char(pick_delim($urandom_range(0, 4)));
        if ($urandom_range(0, 3) == 0) send_char(pick_delim($urandom_range(0, 4)));
    endtask

    // Holds the sender off until every owed byte has arrived, then lets the
    // block settle, since a digit may still be in flight with nothing owed.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (decoder.pending_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        decoder.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Writes all four registers back to back; only called while the block is idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic fmt, input logic conv);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_WORD_FORMAT, {{(CFG_DATA_W-1){1'b0}}, fmt});
        write_reg(CFG_CONVERT, {{(CFG_DATA_W-1){1'b0}}, conv});
        i_cfg_we <= 1'b0;
    endtask

    // The first phases hit the width extremes, including the values that clamp.
    function automatic logic [CFG_DATA_W-1:0] pick_width(int p);
        case (p)
            0:       return 13'd1;
            1:       return 13'd4096;
            2:       return 13'd8191;
            3:       return 13'd0;
            default: return ($urandom_range(0, 1) == 1) ? 13'($urandom_range(1, 40))
                                                       : 13'($urandom_range(1, 4096));
        endcase
    endfunction

    // Heights stay well above the rows reached so the image keeps going until
    // the closing phase.
    function automatic logic [CFG_DATA_W-1:0] pick_height(int p);
        case (p)
            0:       return 13'd8191;
            1:       return 13'd4096;
            default: return 13'($urandom_range(2048, 8191));
        endcase
    endfunction

    initial begin
        int                    phase_start;
        logic [CFG_DATA_W-1:0] final_h;
        decoder = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings (one byte per row, eight rows), so
        // only four tokens are closed here. It opens with a delimiter while no
        // token is open, runs a six-digit token through all digit extremes so only
        // its low 16 bits survive, puts the characters just outside each digit
        // range inside a token where they must be ignored, feeds codes above 127,
        // and closes tokens with the comma, tab, newline and close brace.
        send_char(CH_SPACE);
        send_text("09AFaf,");
        send_text("1G@/:`g2\t");
        send_char(8'h80);
        send_char(8'hff);
        send_text("3\nF}");
        wait_idle();

        // Random phases: each one rewrites every register, then streams tokens.
        // Bits 0 and 1 of the phase number walk through all format and
        // conversion combinations. Now and then the sender pauses until every
        // owed byte has come out.
        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(pick_width(p), pick_height(p), p[0], p[1]);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_token();
                if ($urandom_range(0, 39) == 0) wait_idle();
            end
            wait_idle();
        end

        // Closing phase: the image ends either through an early end of input,
        // sometimes with a token left open, or by lowering the height so that a
        // coming row end is the final one.
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            configure(13'($urandom_range(1, 40)), 13'd4096, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 12)) send_token();
            if ($urandom_range(0, 1) == 1)
                send_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
            send_eoi();
        end else begin
            case ($urandom_range(0, 2))
                0:       final_h = 13'd0;
                1:       final_h = 13'd1;
                default: final_h = 13'(decoder.rows_done + $urandom_range(1, 4));
            endcase
            configure(13'($urandom_range(1, 40)), final_h, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            while (!decoder.done) send_token();
        end

        // Once the image is done, tokens and a further end of input must all be
        // swallowed without any result.
        repeat (8) send_token();
        send_eoi();
        send_token();
        wait_idle();

        if (decoder.mismatch_count == 0 && decoder.pending_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run with every gap and stall at
    // its longest.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
